### hw/rtl/kbd_pkg.sv
package kbd_pkg;

   // pending prefix codes
   localparam logic [1:0] PREFIX_NONE = 2'd0;
   localparam logic [1:0] PREFIX_E0   = 2'd1;
   localparam logic [1:0] PREFIX_E1   = 2'd2;

   localparam logic [7:0] BYTE_E0 = 8'hE0;
   localparam logic [7:0] BYTE_E1 = 8'hE1;

   // set 1 make codes with special handling
   localparam logic [6:0] KC_SHIFT_L  = 7'd42;
   localparam logic [6:0] KC_SHIFT_R  = 7'd54;
   localparam logic [6:0] KC_ALT      = 7'd56;
   localparam logic [6:0] KC_CTRL     = 7'd29;
   localparam logic [6:0] KC_CAPS     = 7'd58;
   localparam logic [6:0] KC_SCROLL   = 7'd70;
   localparam logic [6:0] KC_NUM      = 7'd69;
   localparam logic [6:0] KC_PAD_LO   = 7'd71;
   localparam logic [6:0] KC_PAD_HI   = 7'd83;
   localparam logic [6:0] KC_DIVIDE   = 7'd53;

   localparam logic [7:0] DIVIDE_CODE_RESET = 8'd53;
   localparam logic [7:0] CHAR_SLASH        = 8'd47;

   typedef struct packed {
      logic shift;
      logic alt_l;
      logic alt_r;
      logic ctrl_l;
      logic ctrl_r;
      logic caps;
      logic num;
      logic scroll;
   } mod_type;

   function automatic logic is_letter(input logic [6:0] code);
      return (code >= 7'd16 && code <= 7'd26) || (code >= 7'd30 && code <= 7'd40) ||
             (code >= 7'd44 && code <= 7'd50);
   endfunction

   function automatic logic [7:0] plain_char(input logic [6:0] code);
      logic [7:0] ch;
      case (code)
         7'd2:  ch = 8'd49;   7'd3:  ch = 8'd50;   7'd4:  ch = 8'd51;
         7'd5:  ch = 8'd52;   7'd6:  ch = 8'd53;   7'd7:  ch = 8'd54;
         7'd8:  ch = 8'd55;   7'd9:  ch = 8'd56;   7'd10: ch = 8'd57;
         7'd11: ch = 8'd48;   7'd12: ch = 8'd225;  7'd13: ch = 8'd39;
         7'd14: ch = 8'd8;    7'd15: ch = 8'd9;    7'd16: ch = 8'd113;
         7'd17: ch = 8'd119;  7'd18: ch = 8'd101;  7'd19: ch = 8'd114;
         7'd20: ch = 8'd116;  7'd21: ch = 8'd122;  7'd22: ch = 8'd117;
         7'd23: ch = 8'd105;  7'd24: ch = 8'd111;  7'd25: ch = 8'd112;
         7'd26: ch = 8'd129;  7'd27: ch = 8'd43;   7'd28: ch = 8'd10;
         7'd30: ch = 8'd97;   7'd31: ch = 8'd115;  7'd32: ch = 8'd100;
         7'd33: ch = 8'd102;  7'd34: ch = 8'd103;  7'd35: ch = 8'd104;
         7'd36: ch = 8'd106;  7'd37: ch = 8'd107;  7'd38: ch = 8'd108;
         7'd39: ch = 8'd148;  7'd40: ch = 8'd132;  7'd41: ch = 8'd94;
         7'd43: ch = 8'd35;   7'd44: ch = 8'd121;  7'd45: ch = 8'd120;
         7'd46: ch = 8'd99;   7'd47: ch = 8'd118;  7'd48: ch = 8'd98;
         7'd49: ch = 8'd110;  7'd50: ch = 8'd109;  7'd51: ch = 8'd44;
         7'd52: ch = 8'd46;   7'd53: ch = 8'd45;   7'd55: ch = 8'd42;
         7'd57: ch = 8'd32;   7'd74: ch = 8'd45;   7'd78: ch = 8'd43;
         7'd86: ch = 8'd60;
         default: ch = 8'd0;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] shift_char(input logic [6:0] code);
      logic [7:0] ch;
      case (code)
         7'd2:  ch = 8'd33;   7'd3:  ch = 8'd34;   7'd4:  ch = 8'd21;
         7'd5:  ch = 8'd36;   7'd6:  ch = 8'd37;   7'd7:  ch = 8'd38;
         7'd8:  ch = 8'd47;   7'd9:  ch = 8'd40;   7'd10: ch = 8'd41;
         7'd11: ch = 8'd61;   7'd12: ch = 8'd63;   7'd13: ch = 8'd96;
         7'd16: ch = 8'd81;   7'd17: ch = 8'd87;   7'd18: ch = 8'd69;
         7'd19: ch = 8'd82;   7'd20: ch = 8'd84;   7'd21: ch = 8'd90;
         7'd22: ch = 8'd85;   7'd23: ch = 8'd73;   7'd24: ch = 8'd79;
         7'd25: ch = 8'd80;   7'd26: ch = 8'd154;  7'd27: ch = 8'd42;
         7'd30: ch = 8'd65;   7'd31: ch = 8'd83;   7'd32: ch = 8'd68;
         7'd33: ch = 8'd70;   7'd34: ch = 8'd71;   7'd35: ch = 8'd72;
         7'd36: ch = 8'd74;   7'd37: ch = 8'd75;   7'd38: ch = 8'd76;
         7'd39: ch = 8'd153;  7'd40: ch = 8'd142;  7'd41: ch = 8'd248;
         7'd43: ch = 8'd39;   7'd44: ch = 8'd89;   7'd45: ch = 8'd88;
         7'd46: ch = 8'd67;   7'd47: ch = 8'd86;   7'd48: ch = 8'd66;
         7'd49: ch = 8'd78;   7'd50: ch = 8'd77;   7'd51: ch = 8'd59;
         7'd52: ch = 8'd58;   7'd53: ch = 8'd95;   7'd57: ch = 8'd32;
         7'd86: ch = 8'd62;
         default: ch = 8'd0;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] altgr_char(input logic [6:0] code);
      logic [7:0] ch;
      case (code)
         7'd3:  ch = 8'd253;  7'd8:  ch = 8'd123;  7'd9:  ch = 8'd91;
         7'd10: ch = 8'd93;   7'd11: ch = 8'd125;  7'd12: ch = 8'd92;
         7'd16: ch = 8'd64;   7'd27: ch = 8'd126;  7'd50: ch = 8'd230;
         7'd86: ch = 8'd124;
         default: ch = 8'd0;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] pad_char(input logic [6:0] code);
      logic [7:0] ch;
      case (code)
         7'd71: ch = 8'd55;   7'd72: ch = 8'd56;   7'd73: ch = 8'd57;
         7'd74: ch = 8'd45;   7'd75: ch = 8'd52;   7'd76: ch = 8'd53;
         7'd77: ch = 8'd54;   7'd78: ch = 8'd43;   7'd79: ch = 8'd49;
         7'd80: ch = 8'd50;   7'd81: ch = 8'd51;   7'd82: ch = 8'd48;
         7'd83: ch = 8'd44;
         default: ch = 8'd0;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] pad_code(input logic [6:0] code);
      logic [7:0] kc;
      case (code)
         7'd71: kc = 8'd8;    7'd72: kc = 8'd9;    7'd73: kc = 8'd10;
         7'd74: kc = 8'd53;   7'd75: kc = 8'd5;    7'd76: kc = 8'd6;
         7'd77: kc = 8'd7;    7'd78: kc = 8'd27;   7'd79: kc = 8'd2;
         7'd80: kc = 8'd3;    7'd81: kc = 8'd4;    7'd82: kc = 8'd11;
         7'd83: kc = 8'd51;
         default: kc = 8'd0;
      endcase
      return kc;
   endfunction

endpackage

### hw/rtl/keyboard_scancode_decoder_top.sv
// channel  | dir | handshake             | payload
// req      | in  | req_tvalid/req_tready | req_tdata[7:0] scan_byte
// rsp      | out | rsp_tvalid/rsp_tready | rsp_tuser pressed, rsp_tdata ascii/key/modifiers
// csr      | in  | csr_wen               | csr_wdata divide_key_code
//
// One word per cycle sustained while rsp is not stalled; an accepted byte is registered in
// the input stage and then in the result register before it appears on rsp.
// Reset (synchronous) clears both stages, the prefix, modifiers and locks, and sets the
// divide key code to 53. While rsp is stalled the input stage still holds one word, and
// bytes that give no result (prefixes, modifiers, locks) pass through without waiting.
module keyboard_scancode_decoder_top
   import kbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scan_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] ascii_char, [15:8] key_code, [16] shift_down,
                                    // [17] alt_left_down, [18] alt_right_down,
                                    // [19] ctrl_left_down, [20] ctrl_right_down,
                                    // [21] caps_on, [22] num_on, [23] scroll_on
   output logic        rsp_tuser,   // [0] pressed
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff;
   logic       rsp_user_ff;
   logic [1:0] prefix_ff, prefix_in;
   mod_type    mod_ff, mod_in;
   logic [7:0] divide_ff;

   logic       is_prefix, down, gives_result, out_free, s1_advance, req_take;
   logic [6:0] code;
   logic [7:0] ch, kc;

   assign code      = s1_byte_ff[6:0];
   assign down      = ~s1_byte_ff[7];
   assign is_prefix = (s1_byte_ff == BYTE_E0) || (s1_byte_ff == BYTE_E1);

   always_comb begin
      gives_result = 1'b0;
      if (!is_prefix) begin
         case (code) inside
            KC_SHIFT_L, KC_SHIFT_R, KC_ALT, KC_CTRL, KC_CAPS, KC_SCROLL:
               gives_result = 1'b0;
            KC_NUM:
               gives_result = mod_ff.ctrl_l;
            default:
               gives_result = 1'b1;
         endcase
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && (!gives_result || out_free);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_take   = req_tvalid && req_tready;

   // prefix and modifier update
   always_comb begin
      mod_in    = mod_ff;
      prefix_in = prefix_ff;
      if (s1_advance) begin
         if (s1_byte_ff == BYTE_E0) begin
            prefix_in = PREFIX_E0;
         end else if (s1_byte_ff == BYTE_E1) begin
            prefix_in = PREFIX_E1;
         end else begin
            prefix_in = PREFIX_NONE;
            case (code) inside
               KC_SHIFT_L, KC_SHIFT_R: mod_in.shift = down;
               KC_ALT: begin
                  if (prefix_ff == PREFIX_E0) mod_in.alt_r = down;
                  else mod_in.alt_l = down;
               end
               KC_CTRL: begin
                  if (prefix_ff == PREFIX_E0) mod_in.ctrl_r = down;
                  else mod_in.ctrl_l = down;
               end
               KC_CAPS:   mod_in.caps   = mod_ff.caps ^ down;
               KC_SCROLL: mod_in.scroll = mod_ff.scroll ^ down;
               KC_NUM:    if (!mod_ff.ctrl_l) mod_in.num = mod_ff.num ^ down;
               default: ;
            endcase
         end
      end
   end

   // translation
   always_comb begin
      kc = {1'b0, code};
      if (code == KC_DIVIDE && prefix_ff == PREFIX_E0) begin
         ch = CHAR_SLASH;
         kc = divide_ff;
      end else if (mod_ff.num && prefix_ff == PREFIX_NONE &&
                   code >= KC_PAD_LO && code <= KC_PAD_HI) begin
         ch = pad_char(code);
         kc = pad_code(code);
      end else if (mod_ff.alt_r) begin
         ch = altgr_char(code);
      end else if (mod_ff.shift || (mod_ff.caps && is_letter(code))) begin
         ch = shift_char(code);
      end else begin
         ch = plain_char(code);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) s1_valid_in = 1'b1;
      else if (s1_advance) s1_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && gives_result) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prefix_ff    <= PREFIX_NONE;
         mod_ff       <= '0;
         divide_ff    <= DIVIDE_CODE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prefix_ff    <= prefix_in;
         mod_ff       <= mod_in;
         if (csr_wen) divide_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_byte_ff <= req_tdata;
      if (s1_advance && gives_result) begin
         rsp_data_ff <= {mod_in.scroll, mod_in.num, mod_in.caps, mod_in.ctrl_r,
                         mod_in.ctrl_l, mod_in.alt_r, mod_in.alt_l, mod_in.shift, kc, ch};
         rsp_user_ff <= down;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_prefix_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && is_prefix) |=> (prefix_ff != PREFIX_NONE && !$rose(rsp_valid_ff)))
      else $error("prefix byte lost or produced a result");

   a_caps_make_only: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_byte_ff == {1'b1, KC_CAPS}) |=> $stable(mod_ff.caps))
      else $error("caps lock changed on break");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input stage empty but not ready");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff && prefix_ff == PREFIX_NONE))
      else $error("reset did not clear control state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(s1_advance && gives_result))
      else $error("pending result overwritten");

endmodule
